// ===== sv/sbspr_pkg.sv =====
`timescale 1ns / 1ps
package sbspr_pkg;

  localparam int REG_BYTES_DEF = 32;

  localparam logic [7:0] HDR_A     = 8'hFF;
  localparam logic [7:0] HDR_B     = 8'hFD;
  localparam logic [7:0] HDR_ZERO  = 8'h00;
  localparam logic [7:0] BCAST_ID  = 8'hFE;
  localparam logic [7:0] STATUS_OP = 8'h55;
  localparam logic [7:0] OP_PING   = 8'h01;
  localparam logic [7:0] OP_READ   = 8'h02;
  localparam logic [7:0] OP_SYNC   = 8'h82;
  localparam logic [7:0] ERR_NONE  = 8'h00;
  localparam logic [7:0] ERR_INSTR = 8'h02;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  typedef struct packed {
    logic       en;
    logic [4:0] idx;
    logic [7:0] data;
  } wr_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/sbspr_regfile.sv =====
`timescale 1ns / 1ps
module sbspr_regfile #(
  parameter int REG_BYTES = sbspr_pkg::REG_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sbspr_pkg::wr_req_t           wr,
  input  logic [$clog2(REG_BYTES)-1:0] rd_addr,
  output logic [7:0]                   rd_data
);
  import sbspr_pkg::*;

  localparam int AW = $clog2(REG_BYTES);

  logic [7:0]           mem [REG_BYTES];
  logic [REG_BYTES-1:0] valid;
  logic [7:0]           rd_raw;
  logic                 rd_ok;
  logic                 wr_hit;

  assign wr_hit = wr.en && ({1'b0, wr.idx} < 6'(REG_BYTES));

  always_ff @(posedge clk) begin
    if (wr_hit) mem[AW'(wr.idx)] <= wr.data;
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_hit) valid[AW'(wr.idx)] <= 1'b1;
      rd_ok <= valid[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_raw : 8'h00;

endmodule

// ===== sv/servo_bus_slave_packet_responder.sv =====
`timescale 1ns / 1ps
// Bus slave responder for protocol 2.0 framing. Each input item is either a received bus byte
// (req_type 0) or a local register-file byte write (req_type 1), taken whenever the input is not
// stalled. A frame that earns a reply stalls the input while the status packet streams out (11
// bytes plus the parameter bytes), each parameter byte costing a register-file read. The register
// file sits in a synchronous memory with per-entry valid bits cleared at reset, so no clearing
// pass is needed.
module servo_bus_slave_packet_responder #(
  parameter int REG_BYTES = sbspr_pkg::REG_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic [4:0] reg_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last_byte
);
  import sbspr_pkg::*;

  localparam int AW = $clog2(REG_BYTES);

  typedef enum logic [3:0] {
    PH_H1, PH_H2, PH_H3, PH_H4, PH_ID, PH_LEN_L, PH_LEN_H, PH_PAY, PH_CRC_L, PH_CRC_H
  } rx_phase_t;

  typedef enum logic [2:0] {TX_IDLE, TX_FIXED, TX_RD, TX_RDW, TX_CRCL, TX_CRCH} tx_state_t;

  logic [7:0]  device_id;
  rx_phase_t   rx_phase;
  logic [7:0]  frame_target;
  logic [15:0] frame_length;
  logic [15:0] payload_count;
  logic [15:0] running_check;
  logic [7:0]  received_lo;
  logic [7:0]  opcode;
  logic [15:0] start_address;
  logic [15:0] read_count;
  logic        listed_flag;

  tx_state_t   tx_state;
  logic [3:0]  tx_pos;
  logic [7:0]  tx_err;
  logic [15:0] tx_n;
  logic [15:0] tx_rem;
  logic [15:0] tx_crc;
  logic [AW-1:0] tx_addr;

  logic        accept;
  logic        bus_byte;
  logic        can_load;
  logic        tx_load;
  logic [15:0] crc_next;
  logic        crc_ok;
  logic        id_ok;
  logic        in_range;
  logic        go;
  logic [7:0]  go_err;
  logic [15:0] go_n;
  logic [15:0] len_out;
  logic [7:0]  fixed_byte;
  logic [7:0]  rd_data;
  wr_req_t     wr;

  assign in_stall = (tx_state != TX_IDLE);
  assign accept   = in_valid && !in_stall;
  assign bus_byte = accept && !req_type;
  assign can_load = !out_valid || !out_stall;
  assign tx_load  = can_load && (tx_state == TX_FIXED || tx_state == TX_RDW ||
                                 tx_state == TX_CRCL || tx_state == TX_CRCH);
  assign crc_next = crc_byte(running_check, data_byte);

  assign wr.en   = accept && req_type;
  assign wr.idx  = reg_index;
  assign wr.data = data_byte;

  sbspr_regfile #(.REG_BYTES(REG_BYTES)) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (tx_addr),
    .rd_data (rd_data)
  );

  assign crc_ok   = (running_check == {data_byte, received_lo});
  assign id_ok    = (frame_target == device_id) || (frame_target == BCAST_ID);
  assign in_range = ({1'b0, start_address} + {1'b0, read_count}) <= 17'(REG_BYTES);

  always_comb begin
    go     = 1'b0;
    go_err = ERR_INSTR;
    go_n   = '0;
    if (bus_byte && rx_phase == PH_CRC_H && frame_length != 16'd0 && crc_ok && id_ok) begin
      unique case (opcode)
        OP_PING: begin
          go     = 1'b1;
          go_err = ERR_NONE;
        end
        OP_READ: begin
          go = 1'b1;
          if (frame_length >= 16'd5 && in_range) begin
            go_err = ERR_NONE;
            go_n   = read_count;
          end
        end
        OP_SYNC: begin
          if (frame_length >= 16'd6 && listed_flag) begin
            go = 1'b1;
            if (in_range) begin
              go_err = ERR_NONE;
              go_n   = read_count;
            end
          end
        end
        default: go = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id     <= 8'd1;
      rx_phase      <= PH_H1;
      frame_target  <= '0;
      frame_length  <= '0;
      payload_count <= '0;
      running_check <= '0;
      received_lo   <= '0;
      opcode        <= '0;
      start_address <= '0;
      read_count    <= '0;
      listed_flag   <= 1'b0;
    end else begin
      if (cfg_we) device_id <= cfg_data;
      if (bus_byte) begin
        unique case (rx_phase)
          PH_H1: if (data_byte == HDR_A) rx_phase <= PH_H2;
          PH_H2: rx_phase <= (data_byte == HDR_A) ? PH_H3 : PH_H1;
          PH_H3: rx_phase <= (data_byte == HDR_B) ? PH_H4 : PH_H1;
          PH_H4: rx_phase <= (data_byte == HDR_ZERO) ? PH_ID : PH_H1;
          PH_ID: begin
            frame_target  <= data_byte;
            running_check <= crc_byte(16'h0000, data_byte);
            rx_phase      <= PH_LEN_L;
          end
          PH_LEN_L: begin
            frame_length  <= {8'h00, data_byte};
            running_check <= crc_next;
            rx_phase      <= PH_LEN_H;
          end
          PH_LEN_H: begin
            frame_length  <= {data_byte, frame_length[7:0]};
            running_check <= crc_next;
            payload_count <= '0;
            opcode        <= '0;
            start_address <= '0;
            read_count    <= '0;
            listed_flag   <= 1'b0;
            rx_phase      <= ({data_byte, frame_length[7:0]} == 16'd0) ? PH_CRC_L : PH_PAY;
          end
          PH_PAY: begin
            running_check <= crc_next;
            priority case (payload_count)
              16'd0: opcode <= data_byte;
              16'd1: start_address <= {8'h00, data_byte};
              16'd2: start_address <= {data_byte, start_address[7:0]};
              16'd3: read_count <= {8'h00, data_byte};
              16'd4: read_count <= {data_byte, read_count[7:0]};
              default: if (data_byte == device_id) listed_flag <= 1'b1;
            endcase
            payload_count <= payload_count + 16'd1;
            if (payload_count + 16'd1 >= frame_length) rx_phase <= PH_CRC_L;
          end
          PH_CRC_L: begin
            received_lo <= data_byte;
            rx_phase    <= PH_CRC_H;
          end
          PH_CRC_H: rx_phase <= PH_H1;
          default: rx_phase <= PH_H1;
        endcase
      end
    end
  end

  assign len_out = tx_n + 16'd2;

  always_comb begin
    unique case (tx_pos)
      4'd0, 4'd1: fixed_byte = HDR_A;
      4'd2: fixed_byte = HDR_B;
      4'd3: fixed_byte = HDR_ZERO;
      4'd4: fixed_byte = device_id;
      4'd5: fixed_byte = len_out[7:0];
      4'd6: fixed_byte = len_out[15:8];
      4'd7: fixed_byte = STATUS_OP;
      default: fixed_byte = tx_err;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_state  <= TX_IDLE;
      out_valid <= 1'b0;
      tx_pos    <= '0;
      tx_crc    <= '0;
    end else begin
      if (tx_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (tx_state)
        TX_IDLE: begin
          if (go) begin
            tx_state <= TX_FIXED;
            tx_pos   <= '0;
            tx_crc   <= '0;
            tx_err   <= go_err;
            tx_n     <= go_n;
            tx_rem   <= go_n;
            tx_addr  <= AW'(start_address);
          end
        end
        TX_FIXED: begin
          if (can_load) begin
            tx_byte   <= fixed_byte;
            last_byte <= 1'b0;
            if (tx_pos >= 4'd4) tx_crc <= crc_byte(tx_crc, fixed_byte);
            tx_pos <= tx_pos + 4'd1;
            if (tx_pos == 4'd8) tx_state <= (tx_n != 16'd0) ? TX_RD : TX_CRCL;
          end
        end
        TX_RD: tx_state <= TX_RDW;
        TX_RDW: begin
          if (can_load) begin
            tx_byte   <= rd_data;
            last_byte <= 1'b0;
            tx_crc    <= crc_byte(tx_crc, rd_data);
            tx_rem    <= tx_rem - 16'd1;
            tx_addr   <= tx_addr + AW'(1);
            tx_state  <= (tx_rem == 16'd1) ? TX_CRCL : TX_RD;
          end
        end
        TX_CRCL: begin
          if (can_load) begin
            tx_byte   <= tx_crc[7:0];
            last_byte <= 1'b0;
            tx_state  <= TX_CRCH;
          end
        end
        TX_CRCH: begin
          if (can_load) begin
            tx_byte   <= tx_crc[15:8];
            last_byte <= 1'b1;
            tx_state  <= TX_IDLE;
          end
        end
        default: tx_state <= TX_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/sbspr_checker.sv =====
`timescale 1ns / 1ps
module sbspr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] tx_byte,
  input logic       last_byte
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last_byte))
    else $error("stalled output item changed");

  a_busy_mid_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> in_stall)
    else $error("input open while reply unfinished");

  a_release_on_last: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $fell(in_stall) |-> out_valid && last_byte)
    else $error("input released without final reply byte");

endmodule

bind servo_bus_slave_packet_responder sbspr_checker u_sbspr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .tx_byte   (tx_byte),
  .last_byte (last_byte)
);

// ===== tb/servo_bus_slave_packet_responder_tb.sv =====
`timescale 1ns / 1ps
module servo_bus_slave_packet_responder_tb;
  import sbspr_pkg::*;

  localparam int NREG = REG_BYTES_DEF;
  localparam int QUIET_LIMIT = 20000;

  typedef enum logic [3:0] {
    RX_H1, RX_H2, RX_H3, RX_H4, RX_ID, RX_LEN_L, RX_LEN_H, RX_PAY, RX_CRC_L, RX_CRC_H
  } rx_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [4:0] idx;
  } item_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       req_type = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic [4:0] reg_index = 5'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] tx_byte;
  logic       last_byte;

  servo_bus_slave_packet_responder u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .data_byte(data_byte), .reg_index(reg_index), .out_valid(out_valid),
    .out_stall(out_stall), .tx_byte(tx_byte), .last_byte(last_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  m_id;
  rx_phase_t   m_phase;
  logic [7:0]  m_target;
  logic [15:0] m_len, m_cnt, m_crc, m_rcrc, m_addr, m_rcount;
  logic [7:0]  m_op;
  logic        m_listed;
  logic [7:0]  m_regs [NREG];

  reply_t reply_q[$];
  item_t  send_q[$];
  reply_t typed_q[$];
  int errors = 0;
  int replies_seen = 0;
  int frames_sent = 0;
  int quiet = 0;
  bit hold_rx = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h8005) : {c[14:0], 1'b0};
    return c;
  endfunction

  task automatic queue_status(logic [7:0] err, int addr, int n);
    logic [15:0] c;
    logic [15:0] l;
    logic [7:0] body [5];
    c = 16'h0;
    l = 16'(n + 2);
    body = '{m_id, l[7:0], l[15:8], STATUS_OP, err};
    reply_q.push_back('{HDR_A, 1'b0});
    reply_q.push_back('{HDR_A, 1'b0});
    reply_q.push_back('{HDR_B, 1'b0});
    reply_q.push_back('{HDR_ZERO, 1'b0});
    for (int i = 0; i < 5; i++) begin
      c = crc_step(c, body[i]);
      reply_q.push_back('{body[i], 1'b0});
    end
    for (int i = 0; i < n; i++) begin
      c = crc_step(c, m_regs[(addr + i) % NREG]);
      reply_q.push_back('{m_regs[(addr + i) % NREG], 1'b0});
    end
    reply_q.push_back('{c[7:0], 1'b0});
    reply_q.push_back('{c[15:8], 1'b1});
  endtask

  task automatic close_frame();
    bit in_range;
    if (m_len == 0 || m_crc != m_rcrc) return;
    if (m_target != m_id && m_target != BCAST_ID) return;
    in_range = (32'(m_addr) + 32'(m_rcount)) <= NREG;
    case (m_op)
      OP_PING: queue_status(ERR_NONE, 0, 0);
      OP_READ: begin
        if (m_len - 1 < 4 || !in_range) queue_status(ERR_INSTR, 0, 0);
        else queue_status(ERR_NONE, m_addr, m_rcount);
      end
      OP_SYNC: begin
        if (m_len - 1 >= 5 && m_listed) begin
          if (!in_range) queue_status(ERR_INSTR, 0, 0);
          else queue_status(ERR_NONE, m_addr, m_rcount);
        end
      end
      default: queue_status(ERR_INSTR, 0, 0);
    endcase
  endtask

  task automatic predict_item(item_t it);
    logic [7:0] b;
    b = it.data;
    if (it.kind) begin
      m_regs[it.idx] = b;
      return;
    end
    case (m_phase)
      RX_H1: if (b == HDR_A) m_phase = RX_H2;
      RX_H2: m_phase = (b == HDR_A) ? RX_H3 : RX_H1;
      RX_H3: m_phase = (b == HDR_B) ? RX_H4 : RX_H1;
      RX_H4: m_phase = (b == HDR_ZERO) ? RX_ID : RX_H1;
      RX_ID: begin
        m_target = b;
        m_crc = crc_step(16'h0, b);
        m_phase = RX_LEN_L;
      end
      RX_LEN_L: begin
        m_len = {8'h00, b};
        m_crc = crc_step(m_crc, b);
        m_phase = RX_LEN_H;
      end
      RX_LEN_H: begin
        m_len[15:8] = b;
        m_crc = crc_step(m_crc, b);
        m_cnt = 0; m_op = 0; m_addr = 0; m_rcount = 0; m_listed = 1'b0;
        m_phase = (m_len == 0) ? RX_CRC_L : RX_PAY;
      end
      RX_PAY: begin
        m_crc = crc_step(m_crc, b);
        case (m_cnt)
          0: m_op = b;
          1: m_addr[7:0] = b;
          2: m_addr[15:8] = b;
          3: m_rcount[7:0] = b;
          4: m_rcount[15:8] = b;
          default: if (b == m_id) m_listed = 1'b1;
        endcase
        m_cnt++;
        if (m_cnt >= m_len) m_phase = RX_CRC_L;
      end
      RX_CRC_L: begin
        m_rcrc = {8'h00, b};
        m_phase = RX_CRC_H;
      end
      default: begin
        m_rcrc[15:8] = b;
        m_phase = RX_H1;
        close_frame();
      end
    endcase
  endtask

  task automatic report(string what, reply_t got, reply_t want);
    errors++;
    if (errors <= 30)
      $display("mismatch %s: got %02h/%0b want %02h/%0b at %0t",
               what, got.tx, got.last, want.tx, want.last, $realtime);
  endtask

  // sender
  initial begin
    item_t it;
    int gap;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    forever begin
      if (send_q.size() == 0) begin
        in_valid <= 1'b0;
        wait (send_q.size() != 0);
        @(negedge clk);
      end
      it = send_q[0];
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid  <= 1'b1;
      req_type  <= it.kind;
      data_byte <= it.data;
      reg_index <= it.idx;
      do @(posedge clk); while (in_stall);
      predict_item(it);
      void'(send_q.pop_front());
      @(negedge clk);
    end
  end

  // receiver
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_rx) out_stall <= 1'b1;
      else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid && !hold_rx) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reply_t got, want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{tx_byte, last_byte};
        replies_seen++;
        if (reply_q.size() == 0) begin
          report("unexpected byte", got, got);
        end else begin
          want = reply_q.pop_front();
          if (typed_q.size() != 0) begin
            if (typed_q[0] !== got) report("listed byte", got, typed_q[0]);
            void'(typed_q.pop_front());
          end
          if (got.tx !== want.tx) report("tx_byte", got, want);
          else if (got.last !== want.last) report("last_byte", got, want);
        end
      end
    end
  end

  function automatic item_t rx(logic [7:0] b);
    return '{1'b0, b, 5'($urandom)};
  endfunction

  // build a frame with correct or broken check
  task automatic push_frame(logic [7:0] tgt, logic [7:0] pay[$], bit bad_crc);
    logic [15:0] c;
    logic [15:0] l;
    l = 16'(pay.size());
    c = crc_step(crc_step(crc_step(16'h0, tgt), l[7:0]), l[15:8]);
    foreach (pay[i]) c = crc_step(c, pay[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    send_q.push_back(rx(HDR_A));
    send_q.push_back(rx(HDR_A));
    send_q.push_back(rx(HDR_B));
    send_q.push_back(rx(HDR_ZERO));
    send_q.push_back(rx(tgt));
    send_q.push_back(rx(l[7:0]));
    send_q.push_back(rx(l[15:8]));
    foreach (pay[i]) send_q.push_back(rx(pay[i]));
    send_q.push_back(rx(c[7:0]));
    send_q.push_back(rx(c[15:8]));
    frames_sent++;
  endtask

  task automatic drain();
    wait (send_q.size() == 0 && reply_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_id(logic [7:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_id = v;
  endtask

  task automatic random_frame();
    logic [7:0] pay[$];
    logic [7:0] tgt;
    int n, a, k;
    int pick;
    pick = $urandom_range(0, 9);
    tgt = ($urandom_range(0, 5) == 0) ? 8'($urandom) : (($urandom_range(0, 3) == 0) ? BCAST_ID : m_id);
    a = $urandom_range(0, 36);
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
    case (pick)
      0: pay = '{OP_PING};
      1, 2, 3: pay = '{OP_READ, 8'(a), 8'(a >> 8), 8'(k), 8'(k >> 8)};
      4, 5: begin
        pay = '{OP_SYNC, 8'(a), 8'(a >> 8), 8'(k), 8'(k >> 8)};
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) pay.push_back(($urandom_range(0, 2) == 0) ? m_id : 8'($urandom));
      end
      6: begin
        pay = '{8'($urandom)};
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) pay.push_back(8'($urandom));
      end
      7: pay = '{OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      8: begin
        pay = '{OP_READ};
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) pay.push_back(8'($urandom));
      end
      default: pay = {};
    endcase
    push_frame(tgt, pay, $urandom_range(0, 9) == 0);
  endtask

  typedef struct {
    logic [7:0] tgt;
    logic [7:0] op;
    int         a;
    int         k;
    bit         bad;
    int         err;  // -1: checked by predictor only
  } row_t;

  initial begin
    row_t dir [10];
    logic [7:0] pay[$];
    logic [7:0] drop[$];
    int sent;
    m_id = 8'd1;
    m_phase = RX_H1;
    m_target = 0; m_len = 0; m_cnt = 0; m_crc = 0; m_rcrc = 0;
    m_op = 0; m_addr = 0; m_rcount = 0; m_listed = 1'b0;
    foreach (m_regs[i]) m_regs[i] = 8'h00;
    wait (!rst);
    // ping after reset, full-range read, out of range, unknown opcode, etc.
    dir = '{
      '{8'd1,     OP_PING, 0,  0,  0, 0},
      '{8'd1,     OP_READ, 0,  32, 0, 0},
      '{8'd1,     OP_READ, 31, 2,  0, 2},
      '{8'd1,     8'h7F,   0,  0,  0, 2},
      '{BCAST_ID, OP_READ, 0,  1,  0, -1},
      '{8'd1,     OP_PING, 0,  0,  1, -1},
      '{8'd9,     OP_PING, 0,  0,  0, -1},
      '{8'd1,     OP_READ, 16'hFFFF, 16'hFFFF, 0, 2},
      '{8'd1,     OP_SYNC, 0,  3,  0, -1},
      '{8'd1,     8'h00,   0,  0,  0, 2}
    };
    // header noise, broken header, zero length frame, register writes
    send_q.push_back(rx(8'h00));
    send_q.push_back(rx(HDR_A));
    send_q.push_back(rx(HDR_B));
    send_q.push_back('{1'b1, 8'hFF, 5'd31});
    send_q.push_back('{1'b1, 8'hA5, 5'd0});
    send_q.push_back('{1'b1, 8'h5A, 5'd16});
    push_frame(8'd1, drop, 1'b0);
    foreach (dir[r]) begin
      pay = '{dir[r].op, 8'(dir[r].a), 8'(dir[r].a >> 8), 8'(dir[r].k), 8'(dir[r].k >> 8)};
      if (dir[r].op == OP_PING || dir[r].op == 8'h7F || dir[r].op == 8'h00) pay = '{dir[r].op};
      if (dir[r].op == OP_SYNC) begin
        pay.push_back(8'd3);
        pay.push_back(8'd1);
      end
      if (dir[r].err >= 0 && dir[r].op != OP_READ || dir[r].err == 2) begin
        typed_q.push_back('{HDR_A, 1'b0});
        typed_q.push_back('{HDR_A, 1'b0});
        typed_q.push_back('{HDR_B, 1'b0});
        typed_q.push_back('{HDR_ZERO, 1'b0});
        typed_q.push_back('{8'd1, 1'b0});
        typed_q.push_back('{8'd2, 1'b0});
        typed_q.push_back('{8'd0, 1'b0});
        typed_q.push_back('{STATUS_OP, 1'b0});
        typed_q.push_back('{8'(dir[r].err), 1'b0});
      end
      push_frame(dir[r].tgt, pay, dir[r].bad);
      drain();
      typed_q.delete();
    end
    // several device ids, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      set_id(ph == 0 ? 8'd0 : ph == 1 ? 8'd253 : ph == 4 ? 8'd1 : 8'($urandom_range(0, 253)));
      sent = 0;
      while (sent < 20) begin
        if ($urandom_range(0, 3) == 0) begin
          send_q.push_back('{1'b1, 8'($urandom), 5'($urandom)});
          sent++;
        end else if ($urandom_range(0, 7) == 0) begin
          send_q.push_back(rx(8'($urandom)));
          sent++;
        end else begin
          random_frame();
          sent += 12;
        end
        if (ph == 2 && sent > 8 && !hold_rx) begin
          pay = '{OP_READ, 8'd0, 8'd0, 8'd32, 8'd0};
          push_frame(BCAST_ID, pay, 1'b0);
          push_frame(BCAST_ID, pay, 1'b0);
          hold_rx = 1'b1;
          fork
            begin
              repeat (400) @(posedge clk);
              hold_rx = 1'b0;
            end
          join_none
        end
        wait (send_q.size() < 4);
      end
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d frames across device ids 0, 253 and random ones; %0d reply bytes",
             frames_sent, replies_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sbspr_pkg.sv
sv/sbspr_regfile.sv
sv/servo_bus_slave_packet_responder.sv
sv/sbspr_checker.sv
tb/servo_bus_slave_packet_responder_tb.sv
